/* rtl/kbs_pkg.sv */
// ----------------------------------------------------------------------------
// kbs_pkg
// shared types, constants and the 7-bit shuffle for the bit-shuffle cipher
// ----------------------------------------------------------------------------
`default_nettype none

package kbs_pkg;

  localparam int KEY_MAX = 16;
  localparam int ADDR_W  = $clog2(KEY_MAX);
  localparam int LEN_W   = 5;

  // configuration register indexes
  localparam logic [7:0] REG_KEY_LOW  = 8'd0;
  localparam logic [7:0] REG_KEY_HIGH = 8'd1;
  localparam logic [7:0] REG_KEY_LEN  = 8'd2;
  localparam logic [7:0] REG_MODE     = 8'd3;

  // shuffle selectors
  localparam logic [1:0] SEL_MIRROR = 2'd0;
  localparam logic [1:0] SEL_GROUP  = 2'd1;
  localparam logic [1:0] SEL_INVERT = 2'd2;
  localparam logic [1:0] SEL_PAIRS  = 2'd3;

  // request into the output stage
  typedef struct packed {
    logic load;
    logic decrypt;
    logic last;
  } xf_req_t;

  function automatic logic [6:0] shuffle7(input logic [6:0] v, input logic [1:0] sel);
    logic [6:0] r;
    r = '0;
    case (sel)
      SEL_MIRROR: begin
        for (int k = 0; k < 7; k++) begin
          r[k] = v[6-k];
        end
      end
      SEL_GROUP:  r = {v[6], v[2:0], v[5:3]};
      SEL_INVERT: r = ~v;
      SEL_PAIRS:  r = {v[6], v[4], v[5], v[2], v[3], v[0], v[1]};
      default:    r = v;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/kbs_ram.sv */
// ----------------------------------------------------------------------------
// kbs_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module kbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

/* rtl/kbs_xform.sv */
// ----------------------------------------------------------------------------
// kbs_xform
// key xor and bit shuffle of one stored byte, held in the output register
// ----------------------------------------------------------------------------
`default_nettype none

module kbs_xform import kbs_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire xf_req_t    req,
  input  wire logic [7:0] data_in,
  input  wire logic [7:0] key_byte,
  output logic            out_free,
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
  output logic            m_axis_tlast    // last_of_block
);

  logic [7:0] enc_mix;
  logic [7:0] result;

  always_comb begin
    enc_mix = data_in ^ key_byte;
    if (req.decrypt) begin
      result = {1'b0, shuffle7(data_in[6:0], key_byte[1:0])} ^ key_byte;
    end else begin
      result = {1'b0, shuffle7(enc_mix[6:0], key_byte[1:0])};
    end
  end

  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (req.load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
    if (req.load) begin
      m_axis_tdata <= result;
      m_axis_tlast <= req.last;
    end
  end

endmodule

`default_nettype wire

/* rtl/keyed_bit_shuffle_block_cipher.sv */
// ----------------------------------------------------------------------------
// keyed_bit_shuffle_block_cipher
// block-reversing bit-shuffle cipher with a 16-byte key
// ----------------------------------------------------------------------------
// Text bytes stream in on s_axis and are written into a 16-entry block
// store. A block closes when it holds key_length bytes (0 counts as 1,
// anything above 16 as 16) or when a byte arrives with tlast set. The block
// is then read back from the store in reversed order and every byte goes
// out on m_axis after the keyed xor and 7-bit shuffle; tlast marks the
// final byte of each block. Filling accepts one byte per cycle; draining
// reads the single store port (registered read) into the output register,
// issuing the next read only once the last one has returned and the output
// register can take it. While a block drains no input is taken; once
// the last read is issued the block store is free and filling resumes even
// while the final result still waits in the output register. The cfg port
// is always ready; write it only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_bit_shuffle_block_cipher import kbs_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  // input text
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  wire logic        s_axis_tlast,   // end_of_text
  // output text
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [7:0] out_byte
  output logic             m_axis_tlast,   // last_of_block
  // configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  typedef enum logic [1:0] {
    ST_FILL  = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

  // configuration registers
  logic [63:0]      key_low;
  logic [63:0]      key_high;
  logic [LEN_W-1:0] key_len;
  logic             decrypt;

  state_t            state;
  logic [ADDR_W-1:0] fill_count;  // bytes in the open block
  logic [ADDR_W-1:0] last_idx;    // block length minus one while draining
  logic [ADDR_W-1:0] drain_p;     // next output position to read
  logic              rd_pend;     // store read in flight
  logic [ADDR_W-1:0] pend_p;
  logic [ADDR_W-1:0] pend_src;
  logic              pend_last;

  logic              in_xact;
  logic              close_block;
  logic [LEN_W-1:0]  eff_len;
  logic [LEN_W-1:0]  count_inc;
  logic              out_free;
  logic              issue;
  logic [ADDR_W-1:0] drain_src;
  logic [ADDR_W-1:0] ram_addr;
  logic [7:0]        ram_q;
  logic [ADDR_W-1:0] key_idx;
  logic [127:0]      key_all;
  logic [7:0]        key_sel;
  xf_req_t           xf_req;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low  <= '0;
      key_high <= '0;
      key_len  <= LEN_W'(1);
      decrypt  <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_KEY_LOW:  key_low  <= cfg_data;
        REG_KEY_HIGH: key_high <= cfg_data;
        REG_KEY_LEN:  key_len  <= cfg_data[LEN_W-1:0];
        REG_MODE:     decrypt  <= cfg_data[0];
        default:      ;
      endcase
    end
  end

  // clamp the block length into 1..KEY_MAX
  always_comb begin
    if (key_len == '0) begin
      eff_len = LEN_W'(1);
    end else if (key_len > LEN_W'(KEY_MAX)) begin
      eff_len = LEN_W'(KEY_MAX);
    end else begin
      eff_len = key_len;
    end
  end

  assign s_axis_tready = (state == ST_FILL);
  assign in_xact       = s_axis_tvalid && s_axis_tready;
  assign count_inc     = {1'b0, fill_count} + LEN_W'(1);
  assign close_block   = in_xact && (s_axis_tlast || count_inc >= eff_len);

  // read one entry at a time, only when the output register can take it
  assign issue     = (state == ST_DRAIN) && !rd_pend && out_free;
  assign drain_src = last_idx - drain_p;
  assign ram_addr  = (state == ST_FILL) ? fill_count : drain_src;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_FILL;
      fill_count <= '0;
      rd_pend    <= 1'b0;
    end else begin
      rd_pend <= issue;
      case (state)
        ST_FILL: begin
          if (close_block) begin
            state      <= ST_DRAIN;
            fill_count <= '0;
          end else if (in_xact) begin
            fill_count <= fill_count + ADDR_W'(1);
          end
        end
        ST_DRAIN: begin
          if (issue && drain_p == last_idx) begin
            state <= ST_FILL;
          end
        end
        default: state <= ST_FILL;
      endcase
    end
  end

  // drain bookkeeping, no reset needed
  always_ff @(posedge clk) begin
    if (close_block) begin
      last_idx <= fill_count;
      drain_p  <= '0;
    end else if (issue) begin
      drain_p <= drain_p + ADDR_W'(1);
    end
    if (issue) begin
      pend_p    <= drain_p;
      pend_src  <= drain_src;
      pend_last <= (drain_p == last_idx);
    end
  end

  kbs_ram #(
    .WIDTH(8),
    .DEPTH(KEY_MAX)
  ) u_store (
    .clk  (clk),
    .we   (in_xact),
    .addr (ram_addr),
    .wdata(s_axis_tdata),
    .rdata(ram_q)
  );

  // key byte follows the output position when decrypting, the source otherwise
  assign key_all = {key_high, key_low};
  assign key_idx = decrypt ? pend_p : pend_src;
  assign key_sel = key_all[key_idx*8 +: 8];

  always_comb begin
    xf_req.load    = rd_pend;
    xf_req.decrypt = decrypt;
    xf_req.last    = pend_last;
  end

  kbs_xform u_xform (
    .clk          (clk),
    .rst          (rst),
    .req          (xf_req),
    .data_in      (ram_q),
    .key_byte     (key_sel),
    .out_free     (out_free),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

endmodule

`default_nettype wire

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the keyed bit-shuffle block cipher
// ----------------------------------------------------------------------------
// Text bytes go in on s_axis with random bursts and gaps, while m_axis is
// stalled on a changing pattern. A cycle-free model of the cipher sits in
// the bench: every accepted text byte updates its block store, and each
// block that closes queues its reversed, keyed and shuffled bytes. Every
// output transaction is checked against the oldest queued byte. Directed
// tests cover reset values, all four shuffles in both modes, the length
// limits, short blocks and register changes inside an open block; then
// random phases run with fresh keys, lengths and modes.
// ----------------------------------------------------------------------------

module tb_top;
  import kbs_pkg::*;

  // index that maps to no register, writes to it must change nothing
  localparam logic [7:0] REG_UNUSED = 8'd4;
  localparam int DIRECTED_ITEMS = 21;
  localparam int RANDOM_ITEMS   = 330;

  // one output transaction as the model expects it
  typedef struct packed {
    logic [7:0] text;
    logic       last;
  } cipher_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] in_byte
  logic        s_axis_tlast = 1'b0;    // end_of_text
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;           // [7:0] out_byte
  logic        m_axis_tlast;           // last_of_block
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = 8'h00;
  logic [63:0] cfg_data = 64'h0;

  keyed_bit_shuffle_block_cipher DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #6 clk = ~clk;

  // cipher model state, mirrors the block registers and the open block
  logic [63:0] key_low_m;
  logic [63:0] key_high_m;
  logic [4:0]  key_len_m;
  logic        decrypt_m;
  logic [7:0]  open_block [KEY_MAX];
  int          open_fill;

  cipher_byte_t expected_cipher_bytes [$];
  int          mismatches = 0;
  int          items_sent = 0;
  int          burst_left = 0;

  // 7-bit shuffle picked by the low two key bits, bit 7 is not carried
  function automatic logic [6:0] shuffle_bits(input logic [6:0] v, input logic [1:0] sel);
    logic [6:0] r;
    r = v;
    case (sel)
      SEL_MIRROR: begin
        for (int k = 0; k < 7; k++) r[k] = v[6-k];
      end
      SEL_GROUP: begin
        r[2:0] = v[5:3];
        r[5:3] = v[2:0];
      end
      SEL_INVERT: r = v ^ 7'h7f;
      SEL_PAIRS: begin
        for (int k = 0; k < 6; k += 2) begin
          r[k]   = v[k+1];
          r[k+1] = v[k];
        end
      end
      default: r = v;
    endcase
    return r;
  endfunction

  // accepted text byte: store it, and on block close queue the reversed output
  task automatic absorb_text_byte(input logic [7:0] b, input logic eot);
    logic [127:0] key_all;
    logic [7:0]   kb;
    logic [7:0]   t;
    int           eff_len;
    int           n;
    int           src;
    cipher_byte_t res;
    key_all = {key_high_m, key_low_m};
    // out-of-range lengths clamp to 1 and to the store depth
    if (key_len_m == 5'd0) eff_len = 1;
    else if (key_len_m > KEY_MAX) eff_len = KEY_MAX;
    else eff_len = int'(key_len_m);
    if (open_fill < KEY_MAX) open_block[open_fill] = b;
    open_fill++;
    if (open_fill < eff_len && !eot) return;
    n = (open_fill > KEY_MAX) ? KEY_MAX : open_fill;
    for (int p = 0; p < n; p++) begin
      src = n - 1 - p;
      if (decrypt_m) begin
        // decrypt keys by output position, shuffle first then xor all 8 bits
        kb = key_all[8*p +: 8];
        res.text = {1'b0, shuffle_bits(open_block[src][6:0], kb[1:0])} ^ kb;
      end else begin
        // encrypt keys by stored position, xor first then shuffle
        kb = key_all[8*src +: 8];
        t = open_block[src] ^ kb;
        res.text = {1'b0, shuffle_bits(t[6:0], kb[1:0])};
      end
      res.last = (p == n - 1);
      expected_cipher_bytes.push_back(res);
    end
    open_fill = 0;
  endtask

  // one text transaction; valid stays high across a burst, a random gap or none between bursts
  task automatic send_byte(input logic [7:0] b, input logic eot);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eot;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    burst_left--;
    items_sent++;
    absorb_text_byte(b, eot);
  endtask

  // stop sending, let every queued byte come out, then give the block time to settle
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (expected_cipher_bytes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // one register write transaction, valid is left high for back-to-back writes
  task automatic cfg_write(input logic [7:0] idx, input logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_KEY_LOW:  key_low_m  = value;
      REG_KEY_HIGH: key_high_m = value;
      REG_KEY_LEN:  key_len_m  = value[4:0];
      REG_MODE:     decrypt_m  = value[0];
      default: ;
    endcase
  endtask

  task automatic load_config(input logic [63:0] klo, input logic [63:0] khi,
                             input logic [63:0] len, input logic [63:0] mode);
    wait_drained();
    cfg_write(REG_KEY_LOW, klo);
    cfg_write(REG_KEY_HIGH, khi);
    cfg_write(REG_KEY_LEN, len);
    cfg_write(REG_MODE, mode);
    cfg_valid <= 1'b0;
  endtask

  // reset registers: zero key, one-byte blocks, encrypt
  task automatic test_reset_state();
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
  endtask

  // key bytes 0..3 pick mirror, group swap, invert and pair swap in turn
  task automatic test_shuffle_selectors();
    load_config(64'h0011_2233_07f2_a15c, 64'h8899_aabb_ccdd_eeff, 64'd4, 64'd0);
    send_byte(8'h7f, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'haa, 1'b0);
    load_config(64'h0011_2233_07f2_a15c, 64'h8899_aabb_ccdd_eeff, 64'd4, 64'd1);
    send_byte(8'h01, 1'b0);
    send_byte(8'hfe, 1'b0);
    send_byte(8'hc3, 1'b0);
    send_byte(8'h3c, 1'b1);
  endtask

  // length 0 acts as 1, lengths past the store act as 16, upper data bits ignored
  task automatic test_length_limits();
    wait_drained();
    cfg_write(REG_KEY_LOW, 64'hffff_ffff_ffff_ffff);
    cfg_write(REG_KEY_HIGH, 64'h0);
    cfg_write(REG_KEY_LEN, 64'hffff_ffff_ffff_ffe0);
    cfg_write(REG_MODE, 64'h2);
    cfg_write(REG_UNUSED, 64'hffff_ffff_ffff_ffff);
    cfg_valid <= 1'b0;
    send_byte(8'h80, 1'b0);
    load_config(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 64'd31, 64'd1);
    send_byte(8'h9d, 1'b0);
    send_byte(8'h62, 1'b1);
  endtask

  // end of text on the first byte of a block closes a one-byte block
  task automatic test_short_block();
    load_config(64'h0000_0000_0000_0033, 64'h0, 64'd5, 64'd0);
    send_byte(8'hff, 1'b1);
  endtask

  // registers rewritten while a block is partly filled
  task automatic test_midblock_changes();
    load_config(64'h1f2e_3d4c_5b6a_7980, 64'h0, 64'd8, 64'd0);
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b0);
    send_byte(8'h33, 1'b0);
    // length drops below the fill, the next byte must close the block
    wait_drained();
    cfg_write(REG_KEY_LEN, 64'd2);
    cfg_valid <= 1'b0;
    send_byte(8'h44, 1'b0);
    load_config(64'h0000_0000_00a5_5a96, 64'h0, 64'd3, 64'd0);
    send_byte(8'h5e, 1'b0);
    send_byte(8'he5, 1'b0);
    // key and mode at block close are the ones that count
    wait_drained();
    cfg_write(REG_KEY_LOW, 64'h0000_0000_00c3_3c69);
    cfg_write(REG_MODE, 64'd1);
    cfg_valid <= 1'b0;
    send_byte(8'h7b, 1'b0);
  endtask

  // random phases: fresh registers, then random text ending each phase on end of text
  task automatic test_random_traffic();
    logic [63:0] len;
    int          pick;
    int          n;
    logic [7:0]  b;
    logic        eot;
    while (items_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
      pick = $urandom_range(0, 19);
      case (pick)
        0: len = 64'd1;
        1, 2: len = 64'd16;
        3: len = 64'd0;
        4: len = 64'($urandom_range(17, 31));
        default: len = 64'($urandom_range(1, 16));
      endcase
      load_config({$urandom, $urandom}, {$urandom, $urandom}, len,
                  64'($urandom_range(0, 1)));
      n = $urandom_range(8, 40);
      for (int i = 0; i < n; i++) begin
        pick = $urandom_range(0, 15);
        b = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hff : 8'($urandom);
        eot = (i == n - 1) || ($urandom_range(0, 11) == 0);
        send_byte(b, eot);
      end
    end
  endtask

  // output side stall pattern, switching style each time the 6-bit stall counter wraps
  int          stall_mode = 0;
  logic [5:0]  stall_cnt = '0;

  always @(posedge clk) begin
    stall_cnt <= stall_cnt + 6'd1;
    if (stall_cnt == 6'd63) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      2: m_axis_tready <= (stall_cnt[1:0] == 2'd0);
      default: m_axis_tready <= stall_cnt[3];
    endcase
  end

  // every output transaction against the oldest expected byte
  always @(posedge clk) begin
    cipher_byte_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_cipher_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output: data %h last %b", m_axis_tdata, m_axis_tlast);
      end else begin
        want = expected_cipher_bytes.pop_front();
        if (m_axis_tdata !== want.text || m_axis_tlast !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected data %h last %b, got data %h last %b",
                     want.text, want.last, m_axis_tdata, m_axis_tlast);
        end
      end
    end
  end

  initial begin
    key_low_m  = '0;
    key_high_m = '0;
    key_len_m  = 5'd1;
    decrypt_m  = 1'b0;
    open_fill  = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_state();
    test_shuffle_selectors();
    test_length_limits();
    test_short_block();
    test_midblock_changes();
    test_random_traffic();

    // drain, then give the output register a little extra time
    s_axis_tvalid <= 1'b0;
    while (expected_cipher_bytes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_cipher_bytes.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #3000000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
